[sv/mwm_pkg.sv]
`default_nettype none
package mwm_pkg;

    localparam int FRAC_BITS       = 14;
    localparam int DUTY_FULL_SCALE = 4096;
    localparam int ONE             = 1 << FRAC_BITS;

    localparam int NWHEEL  = 4;
    localparam int VEL_W   = 16;
    localparam int MAG_W   = 15;
    localparam int DUTY_W  = 13;
    localparam int SUM_W   = VEL_W + 2;
    localparam int ABS_W   = SUM_W - 1;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int V_W     = 15;
    localparam int DIV_STAGES = Q_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_BL = 2;
    localparam int WHEEL_BR = 3;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        sum_t [NWHEEL-1:0] sum;
        logic [MAG_W-1:0]  mag;
    } cmd_t;

    function automatic sum_t sx(input logic [VEL_W-1:0] v);
        sx = sum_t'({{(SUM_W-VEL_W){v[VEL_W-1]}}, v});
    endfunction

endpackage
`default_nettype wire

[sv/mwm_front.sv]
`default_nettype none
module mwm_front
(
    input  wire logic [mwm_pkg::VEL_W-1:0] lateral_vel,
    input  wire logic [mwm_pkg::VEL_W-1:0] forward_vel,
    input  wire logic [mwm_pkg::VEL_W-1:0] turn_rate,
    input  wire logic [mwm_pkg::MAG_W-1:0] magnitude,
    output mwm_pkg::cmd_t                  cmd
);

    mwm_pkg::sum_t vx;
    mwm_pkg::sum_t vy;
    mwm_pkg::sum_t w;

    assign vx = mwm_pkg::sx(lateral_vel);
    assign vy = mwm_pkg::sx(forward_vel);
    assign w  = mwm_pkg::sx(turn_rate);

    // wheel sums of the inverse kinematics
    always_comb
    begin
        cmd.sum[mwm_pkg::WHEEL_FL] = vy + vx + w;
        cmd.sum[mwm_pkg::WHEEL_FR] = vy - vx - w;
        cmd.sum[mwm_pkg::WHEEL_BL] = vy - vx + w;
        cmd.sum[mwm_pkg::WHEEL_BR] = vy + vx - w;
        cmd.mag = magnitude;
    end

endmodule
`default_nettype wire

[sv/mwm_queue.sv]
`default_nettype none
module mwm_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  mwm_pkg::cmd_t      push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output mwm_pkg::cmd_t      head
);

    mwm_pkg::cmd_t mem [mwm_pkg::QUEUE_DEPTH];
    logic [mwm_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [mwm_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [mwm_pkg::PTR_W:0]   count_reg;
    logic [mwm_pkg::PTR_W:0]   count_next;
    logic                      do_pop;

    assign full      = (count_reg == (mwm_pkg::PTR_W+1)'(mwm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[sv/mwm_back.sv]
`default_nettype none
module mwm_back
(
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        head_valid,
    input  mwm_pkg::cmd_t                                    head,
    output logic                                             pop,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output logic [mwm_pkg::NWHEEL-1:0]                       fwd,
    output logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::DUTY_W-1:0]  duty
);

    localparam int DPROD_W = mwm_pkg::V_W + $clog2(mwm_pkg::DUTY_FULL_SCALE) + 1;
    localparam int MPROD_W = mwm_pkg::Q_W + mwm_pkg::MAG_W;

    typedef struct packed {
        logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::ABS_W-1:0] rem;
        logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::Q_W-1:0]   quo;
        logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::Q_W-1:0]   byp;
        logic [mwm_pkg::NWHEEL-1:0]                     neg;
        logic [mwm_pkg::ABS_W-1:0]                      mx;
        logic                                           norm;
        logic [mwm_pkg::MAG_W-1:0]                      mag;
    } div_t;

    logic                                            en;
    div_t                                            stg_reg  [mwm_pkg::DIV_STAGES+1];
    div_t                                            stg_next [mwm_pkg::DIV_STAGES+1];
    logic [mwm_pkg::DIV_STAGES:0]                    vld_reg;
    logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::V_W-1:0]    v_reg;
    logic [mwm_pkg::NWHEEL-1:0]                      vneg_reg;
    logic                                            vvld_reg;
    logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::ABS_W-1:0]  a0;
    logic [mwm_pkg::ABS_W-1:0]                       m01;
    logic [mwm_pkg::ABS_W-1:0]                       m23;
    logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::V_W-1:0]    v_next;
    logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::DUTY_W-1:0] duty_next;
    logic                                            out_valid_reg;
    logic [mwm_pkg::NWHEEL-1:0]                      fwd_reg;
    logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::DUTY_W-1:0] duty_reg;

    assign en        = !(out_valid_reg && out_stall);
    assign pop       = en && head_valid;
    assign out_valid = out_valid_reg;
    assign fwd       = fwd_reg;
    assign duty      = duty_reg;

    // magnitudes, largest magnitude, then restoring division one quotient bit per stage
    always_comb
    begin
        logic [mwm_pkg::ABS_W:0] t;
        for (int k = 0; k < mwm_pkg::NWHEEL; k++)
        begin
            a0[k] = head.sum[k][mwm_pkg::SUM_W-1] ?
                    mwm_pkg::ABS_W'(-head.sum[k]) : mwm_pkg::ABS_W'(head.sum[k]);
        end
        m01 = (a0[0] > a0[1]) ? a0[0] : a0[1];
        m23 = (a0[2] > a0[3]) ? a0[2] : a0[3];
        stg_next[0].mx   = (m01 > m23) ? m01 : m23;
        stg_next[0].norm = (stg_next[0].mx > mwm_pkg::ABS_W'(mwm_pkg::ONE));
        stg_next[0].mag  = head.mag;
        for (int k = 0; k < mwm_pkg::NWHEEL; k++)
        begin
            stg_next[0].rem[k] = a0[k];
            stg_next[0].quo[k] = '0;
            stg_next[0].byp[k] = a0[k][mwm_pkg::Q_W-1:0];
            stg_next[0].neg[k] = head.sum[k][mwm_pkg::SUM_W-1] && (head.mag != '0);
        end
        for (int j = 1; j <= mwm_pkg::DIV_STAGES; j++)
        begin
            stg_next[j] = stg_reg[j-1];
            for (int k = 0; k < mwm_pkg::NWHEEL; k++)
            begin
                t = (j == 1) ? {1'b0, stg_reg[j-1].rem[k]} : {stg_reg[j-1].rem[k], 1'b0};
                if (t >= {1'b0, stg_reg[j-1].mx})
                begin
                    stg_next[j].rem[k] = mwm_pkg::ABS_W'(t - {1'b0, stg_reg[j-1].mx});
                    stg_next[j].quo[k] = {stg_reg[j-1].quo[k][mwm_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    stg_next[j].rem[k] = t[mwm_pkg::ABS_W-1:0];
                    stg_next[j].quo[k] = {stg_reg[j-1].quo[k][mwm_pkg::Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // speed scaling
    always_comb
    begin
        logic [mwm_pkg::Q_W-1:0] n;
        logic [MPROD_W-1:0]      p;
        for (int k = 0; k < mwm_pkg::NWHEEL; k++)
        begin
            n = stg_reg[mwm_pkg::DIV_STAGES].norm ? stg_reg[mwm_pkg::DIV_STAGES].quo[k]
                                                  : stg_reg[mwm_pkg::DIV_STAGES].byp[k];
            p = MPROD_W'(n) * MPROD_W'(stg_reg[mwm_pkg::DIV_STAGES].mag);
            v_next[k] = p[mwm_pkg::FRAC_BITS +: mwm_pkg::V_W];
        end
    end

    // duty with saturation
    always_comb
    begin
        logic [DPROD_W-1:0] d;
        for (int k = 0; k < mwm_pkg::NWHEEL; k++)
        begin
            d = (DPROD_W'(v_reg[k]) * DPROD_W'(mwm_pkg::DUTY_FULL_SCALE))
                >> mwm_pkg::FRAC_BITS;
            if (d > DPROD_W'(mwm_pkg::DUTY_FULL_SCALE))
            begin
                d = DPROD_W'(mwm_pkg::DUTY_FULL_SCALE);
            end
            duty_next[k] = d[mwm_pkg::DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= mwm_pkg::DIV_STAGES; j++)
            begin
                stg_reg[j] <= stg_next[j];
            end
            v_reg    <= v_next;
            vneg_reg <= stg_reg[mwm_pkg::DIV_STAGES].neg;
            fwd_reg  <= ~vneg_reg;
            duty_reg <= duty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            vvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[mwm_pkg::DIV_STAGES-1:0], head_valid};
            vvld_reg      <= vld_reg[mwm_pkg::DIV_STAGES];
            out_valid_reg <= vvld_reg;
        end
    end

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (duty_reg[0] <= mwm_pkg::DUTY_W'(mwm_pkg::DUTY_FULL_SCALE))
                       && (duty_reg[3] <= mwm_pkg::DUTY_W'(mwm_pkg::DUTY_FULL_SCALE)))
        else $error("duty above full scale");

    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[mwm_pkg::DIV_STAGES] && stg_reg[mwm_pkg::DIV_STAGES].norm) |->
            (stg_reg[mwm_pkg::DIV_STAGES].quo[0] <= mwm_pkg::Q_W'(mwm_pkg::ONE))
         && (stg_reg[mwm_pkg::DIV_STAGES].quo[1] <= mwm_pkg::Q_W'(mwm_pkg::ONE)))
        else $error("normalised value above one");

    a_max_ok: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (stg_reg[0].rem[0] <= stg_reg[0].mx)
                    && (stg_reg[0].rem[1] <= stg_reg[0].mx)
                    && (stg_reg[0].rem[2] <= stg_reg[0].mx)
                    && (stg_reg[0].rem[3] <= stg_reg[0].mx))
        else $error("largest magnitude wrong");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(vld_reg))
        else $error("pipe moved while output held");
`endif

endmodule
`default_nettype wire

[sv/mecanum_wheel_mixer_top.sv]
// path: queue, largest-magnitude stage, divider stages, speed and output registers
// throughput: one word per cycle unless the output stalls; 15-stage divider pipeline
// output stall freezes the back pipeline; a 4-word queue keeps taking input until full
// reset (rst_n, async, active low) empties the queue and clears all valid flags
`default_nettype none
module mecanum_wheel_mixer_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mwm_pkg::VEL_W-1:0]     lateral_vel,
    input  wire logic [mwm_pkg::VEL_W-1:0]     forward_vel,
    input  wire logic [mwm_pkg::VEL_W-1:0]     turn_rate,
    input  wire logic [mwm_pkg::MAG_W-1:0]     magnitude,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               front_left_fwd,
    output logic [mwm_pkg::DUTY_W-1:0]         front_left_duty,
    output logic                               front_right_fwd,
    output logic [mwm_pkg::DUTY_W-1:0]         front_right_duty,
    output logic                               back_left_fwd,
    output logic [mwm_pkg::DUTY_W-1:0]         back_left_duty,
    output logic                               back_right_fwd,
    output logic [mwm_pkg::DUTY_W-1:0]         back_right_duty
);

    mwm_pkg::cmd_t                                   cmd;
    mwm_pkg::cmd_t                                   head;
    logic                                            full;
    logic                                            not_empty;
    logic                                            pop;
    logic [mwm_pkg::NWHEEL-1:0]                      fwd;
    logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::DUTY_W-1:0] duty;

    assign in_stall = full;

    mwm_front u_front
    (
        .lateral_vel (lateral_vel),
        .forward_vel (forward_vel),
        .turn_rate   (turn_rate),
        .magnitude   (magnitude),
        .cmd         (cmd)
    );

    mwm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !full),
        .push_data (cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    mwm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .fwd        (fwd),
        .duty       (duty)
    );

    assign front_left_fwd   = fwd[mwm_pkg::WHEEL_FL];
    assign front_left_duty  = duty[mwm_pkg::WHEEL_FL];
    assign front_right_fwd  = fwd[mwm_pkg::WHEEL_FR];
    assign front_right_duty = duty[mwm_pkg::WHEEL_FR];
    assign back_left_fwd    = fwd[mwm_pkg::WHEEL_BL];
    assign back_left_duty   = duty[mwm_pkg::WHEEL_BL];
    assign back_right_fwd   = fwd[mwm_pkg::WHEEL_BR];
    assign back_right_duty  = duty[mwm_pkg::WHEEL_BR];

endmodule
`default_nettype wire

[tb/tb_mecanum_wheel_mixer_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_mecanum_wheel_mixer_top;

    typedef struct packed {
        logic [mwm_pkg::VEL_W-1:0] vx;
        logic [mwm_pkg::VEL_W-1:0] vy;
        logic [mwm_pkg::VEL_W-1:0] w;
        logic [mwm_pkg::MAG_W-1:0] mag;
    } cmd_word_t;

    typedef struct packed {
        logic                       fwd;
        logic [mwm_pkg::DUTY_W-1:0] duty;
    } wheel_out_t;

    typedef wheel_out_t [mwm_pkg::NWHEEL-1:0] drive_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [mwm_pkg::VEL_W-1:0] lateral_vel;
    logic [mwm_pkg::VEL_W-1:0] forward_vel;
    logic [mwm_pkg::VEL_W-1:0] turn_rate;
    logic [mwm_pkg::MAG_W-1:0] magnitude;
    logic out_valid;
    logic out_stall;
    logic front_left_fwd;
    logic [mwm_pkg::DUTY_W-1:0] front_left_duty;
    logic front_right_fwd;
    logic [mwm_pkg::DUTY_W-1:0] front_right_duty;
    logic back_left_fwd;
    logic [mwm_pkg::DUTY_W-1:0] back_left_duty;
    logic back_right_fwd;
    logic [mwm_pkg::DUTY_W-1:0] back_right_duty;

    cmd_word_t cmd_queue[$];
    drive_t    drive_queue[$];
    int        errors;
    int        cycles;
    bit        in_acc;
    bit        calm;
    bit        hold_rx;
    bit        pause_tx;
    int        hold_count;

    localparam int LIMIT = 200000;

    mecanum_wheel_mixer_top dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .lateral_vel(lateral_vel), .forward_vel(forward_vel),
        .turn_rate(turn_rate), .magnitude(magnitude),
        .out_valid(out_valid), .out_stall(out_stall),
        .front_left_fwd(front_left_fwd), .front_left_duty(front_left_duty),
        .front_right_fwd(front_right_fwd), .front_right_duty(front_right_duty),
        .back_left_fwd(back_left_fwd), .back_left_duty(back_left_duty),
        .back_right_fwd(back_right_fwd), .back_right_duty(back_right_duty)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic drive_t mix_wheels(input cmd_word_t c);
        longint vx, vy, w, s[4], a[4], mx, n, v, duty;
        drive_t r;
        vx = longint'($signed(c.vx));
        vy = longint'($signed(c.vy));
        w  = longint'($signed(c.w));
        s[mwm_pkg::WHEEL_FL] = vy + vx + w;
        s[mwm_pkg::WHEEL_FR] = vy - vx - w;
        s[mwm_pkg::WHEEL_BL] = vy - vx + w;
        s[mwm_pkg::WHEEL_BR] = vy + vx - w;
        mx = 0;
        for (int k = 0; k < mwm_pkg::NWHEEL; k++)
        begin
            a[k] = (s[k] < 0) ? -s[k] : s[k];
            if (a[k] > mx)
                mx = a[k];
        end
        for (int k = 0; k < mwm_pkg::NWHEEL; k++)
        begin
            n = a[k];
            if (mx > mwm_pkg::ONE)
                n = (n * mwm_pkg::ONE) / mx;
            v = (n * longint'(c.mag)) >>> mwm_pkg::FRAC_BITS;
            duty = (v * mwm_pkg::DUTY_FULL_SCALE) >>> mwm_pkg::FRAC_BITS;
            if (duty > mwm_pkg::DUTY_FULL_SCALE)
                duty = mwm_pkg::DUTY_FULL_SCALE;
            r[k].fwd  = (s[k] < 0 && c.mag != 0) ? 1'b0 : 1'b1;
            r[k].duty = duty[mwm_pkg::DUTY_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic logic [mwm_pkg::VEL_W-1:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return 16'(-16384);
            1: return 16'(16384);
            2: return 16'($urandom_range(0, 32767) - 16384);
            3: return 16'($urandom);
            4: return 16'($urandom_range(0, 200) - 100);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic push_cmd(input int vx, input int vy, input int w, input int mag);
        cmd_word_t c;
        c.vx = 16'(vx);
        c.vy = 16'(vy);
        c.w = 16'(w);
        c.mag = 15'(mag);
        cmd_queue.push_back(c);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_acc)
            begin
                if (in_acc)
                    void'(cmd_queue.pop_front());
                if (cmd_queue.size() != 0 && !pause_tx
                    && (calm || $urandom_range(0, 99) >= 28))
                begin
                    in_valid    <= 1'b1;
                    lateral_vel <= cmd_queue[0].vx;
                    forward_vel <= cmd_queue[0].vy;
                    turn_rate   <= cmd_queue[0].w;
                    magnitude   <= cmd_queue[0].mag;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_count > 0)
            begin
                out_stall <= 1'b1;
                hold_count <= hold_count - 1;
            end
            else if (hold_rx)
            begin
                out_stall <= 1'b1;
                hold_count <= 300;
                hold_rx <= 1'b0;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < 28);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_acc <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            drive_queue.push_back(mix_wheels(cmd_word_t'{lateral_vel, forward_vel,
                                                         turn_rate, magnitude}));
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_queue.size() == 0)
            begin
                report_mismatch("unexpected word", 0, 0);
            end
            else
            begin
                drive_t e;
                drive_t g;
                e = drive_queue.pop_front();
                g[mwm_pkg::WHEEL_FL] = {front_left_fwd, front_left_duty};
                g[mwm_pkg::WHEEL_FR] = {front_right_fwd, front_right_duty};
                g[mwm_pkg::WHEEL_BL] = {back_left_fwd, back_left_duty};
                g[mwm_pkg::WHEEL_BR] = {back_right_fwd, back_right_duty};
                for (int k = 0; k < mwm_pkg::NWHEEL; k++)
                begin
                    if (g[k].fwd !== e[k].fwd)
                        report_mismatch($sformatf("wheel %0d fwd", k), g[k].fwd, e[k].fwd);
                    if (g[k].duty !== e[k].duty)
                        report_mismatch($sformatf("wheel %0d duty", k), g[k].duty, e[k].duty);
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("mecanum_wheel_mixer_top verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        in_acc = 1'b0;
        calm = 1'b0;
        hold_rx = 1'b0;
        pause_tx = 1'b0;
        hold_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        lateral_vel = '0;
        forward_vel = '0;
        turn_rate = '0;
        magnitude = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_cmd(0, 0, 0, 16384);
        push_cmd(0, 0, 0, 0);
        push_cmd(16384, 16384, 16384, 16384);
        push_cmd(-16384, -16384, -16384, 16384);
        push_cmd(-16384, 16384, -16384, 32767);
        push_cmd(16384, -16384, 16384, 32767);
        push_cmd(-1, 0, 0, 16384);
        push_cmd(-1, 0, 0, 0);
        push_cmd(0, -5, 0, 1);
        push_cmd(8000, 0, 0, 16384);
        push_cmd(0, 8000, 0, 16384);
        push_cmd(0, 0, 8000, 16384);
        push_cmd(16384, 0, 0, 16384);
        push_cmd(5000, 5000, 6384, 16384);
        push_cmd(5000, 5000, 6385, 16384);
        push_cmd(-32768, 32767, -32768, 32767);
        push_cmd(32767, -32768, 32767, 16384);
        push_cmd(-12345, 4321, 999, 20000);
        push_cmd(16384, 16384, -16384, 8192);
        push_cmd(3, -7, 11, 32767);
        wait (cmd_queue.size() == 0 && drive_queue.size() == 0);

        // receiver holds off while the sender keeps offering
        hold_rx = 1'b1;
        for (int i = 0; i < 40; i++)
            push_cmd(rand_vel(), rand_vel(), rand_vel(), $urandom_range(0, 16384));
        wait (cmd_queue.size() == 0 && drive_queue.size() == 0);

        // sender pauses after the pipeline has drained
        pause_tx = 1'b1;
        repeat (30) @(posedge clk);
        pause_tx = 1'b0;

        for (int i = 0; i < 400; i++)
        begin
            int m;
            case ($urandom_range(0, 4))
                0: m = 16384;
                1: m = 0;
                2: m = $urandom_range(0, 32767);
                default: m = $urandom_range(0, 16384);
            endcase
            if (i == 150)
            begin
                wait (cmd_queue.size() == 0);
                calm = 1'b1;
            end
            if (i == 260)
            begin
                wait (cmd_queue.size() == 0);
                calm = 1'b0;
            end
            push_cmd(rand_vel(), rand_vel(), rand_vel(), m);
        end
        wait (cmd_queue.size() == 0);
        wait (drive_queue.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("mecanum_wheel_mixer_top verification clean");
        else
            $display("mecanum_wheel_mixer_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
sv/mwm_pkg.sv
sv/mwm_front.sv
sv/mwm_queue.sv
sv/mwm_back.sv
sv/mecanum_wheel_mixer_top.sv
tb/tb_mecanum_wheel_mixer_top.sv
